// ===== rtl/sorted_neighbor_list_replace_top_assert.svh =====
// Assertion macros shared by the block's modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SORTED_NEIGHBOR_LIST_REPLACE_TOP_ASSERT_SVH
`define SORTED_NEIGHBOR_LIST_REPLACE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SNLR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SNLR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/snlr_pkg.sv =====
`timescale 1ns / 1ps

package snlr_pkg;

    localparam int VERTICES_DEF   = 256;
    localparam int MAX_DEGREE_DEF = 64;

    // Operation codes; read is the remaining code and falls through dispatch.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_REPLACE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] row_vertex;
        logic [6:0] position;
        logic [7:0] new_neighbor;
    } req_t;

    typedef struct packed {
        logic [6:0] new_count;
        logic       removed;
        logic [7:0] read_value;
        logic [1:0] status;
    } rsp_t;

    typedef logic [5:0] upc_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_CLR_LAST,
        C_OP_CLEAR,
        C_OP_APPEND,
        C_OP_REPLACE,
        C_POS_BAD,
        C_FULL,
        C_K_LE_N,
        C_K_GT0,
        C_U_LT,
        C_U_GT,
        C_U_EQ
    } cond_t;

    typedef enum logic [1:0] {N_HOLD, N_ZERO, N_INC, N_DEC} cnt_op_t;
    typedef enum logic [2:0] {K_HOLD, K_POS_P1, K_POS_M1, K_INC, K_DEC, K_ADD2} k_op_t;
    typedef enum logic [2:0] {A_K, A_KM1, A_KP1, A_POS, A_CNTP1} asel_t;
    typedef enum logic {W_CUR, W_NB} wsel_t;
    typedef enum logic [1:0] {SS_NONE, SS_POS, SS_FULL} sset_t;

    typedef struct packed {
        logic    accept;
        logic    clr_wr;
        logic    cnt_rd;
        logic    cnt_ld;
        logic    cnt_wr;
        cnt_op_t cnt_op;
        logic    mem_rd;
        logic    mem_wr;
        asel_t   asel;
        wsel_t   wsel;
        k_op_t   k_op;
        sset_t   sset;
        logic    set_removed;
        logic    rd_ld;
        logic    done;
        cond_t   cond;
        logic    inv;
        upc_t    target;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic op_clear;
        logic op_append;
        logic op_replace;
        logic pos_bad;
        logic full;
        logic k_le_n;
        logic k_gt0;
        logic u_lt;
        logic u_gt;
        logic u_eq;
    } flags_t;

    // Program step labels
    localparam upc_t U_CLR     = 6'd0;
    localparam upc_t U_IDLE    = 6'd1;
    localparam upc_t U_FETCH   = 6'd2;
    localparam upc_t U_LOADCNT = 6'd3;
    localparam upc_t U_D0      = 6'd4;
    localparam upc_t U_D1      = 6'd5;
    localparam upc_t U_D2      = 6'd6;
    localparam upc_t U_READ    = 6'd7;
    localparam upc_t U_READ_RD = 6'd8;
    localparam upc_t U_READ_LD = 6'd9;
    localparam upc_t U_POS_ERR = 6'd10;
    localparam upc_t U_CLEAR   = 6'd11;
    localparam upc_t U_APPEND  = 6'd12;
    localparam upc_t U_APP_WR  = 6'd13;
    localparam upc_t U_FULL    = 6'd14;
    localparam upc_t U_REPL    = 6'd15;
    localparam upc_t U_REPL_RD = 6'd16;
    localparam upc_t U_REPL_CM = 6'd17;
    localparam upc_t U_RIGHT   = 6'd18;
    localparam upc_t U_RLOOP   = 6'd19;
    localparam upc_t U_RRD     = 6'd20;
    localparam upc_t U_RCMP    = 6'd21;
    localparam upc_t U_RMOVE   = 6'd22;
    localparam upc_t U_RCHK    = 6'd23;
    localparam upc_t U_RDEL    = 6'd24;
    localparam upc_t U_RPUT    = 6'd25;
    localparam upc_t U_LEFT    = 6'd26;
    localparam upc_t U_LLOOP   = 6'd27;
    localparam upc_t U_LRD     = 6'd28;
    localparam upc_t U_LCMP    = 6'd29;
    localparam upc_t U_LMOVE   = 6'd30;
    localparam upc_t U_LCHK    = 6'd31;
    localparam upc_t U_LDEL    = 6'd32;
    localparam upc_t U_LPUT    = 6'd33;
    localparam upc_t U_DLOOP   = 6'd34;
    localparam upc_t U_DRD     = 6'd35;
    localparam upc_t U_DMOVE   = 6'd36;
    localparam upc_t U_DEND    = 6'd37;
    localparam upc_t U_WB      = 6'd38;
    localparam upc_t U_DONE    = 6'd39;

    // Control store. Jump is taken when the selected condition, xor inv, is true.
    function automatic ctrl_t ucode(upc_t s);
        ctrl_t c;
        c = '0;
        unique case (s)
            U_CLR:     begin c.clr_wr = 1'b1; c.cond = C_CLR_LAST; c.inv = 1'b1;
                             c.target = U_CLR; end
            U_IDLE:    begin c.accept = 1'b1; c.cond = C_IN_VALID; c.inv = 1'b1;
                             c.target = U_IDLE; end
            U_FETCH:   begin c.cnt_rd = 1'b1; end
            U_LOADCNT: begin c.cnt_ld = 1'b1; end
            U_D0:      begin c.cond = C_OP_CLEAR; c.target = U_CLEAR; end
            U_D1:      begin c.cond = C_OP_APPEND; c.target = U_APPEND; end
            U_D2:      begin c.cond = C_OP_REPLACE; c.target = U_REPL; end
            U_READ:    begin c.cond = C_POS_BAD; c.target = U_POS_ERR; end
            U_READ_RD: begin c.mem_rd = 1'b1; c.asel = A_POS; end
            U_READ_LD: begin c.rd_ld = 1'b1; c.cond = C_ALWAYS; c.target = U_WB; end
            U_POS_ERR: begin c.sset = SS_POS; c.cond = C_ALWAYS; c.target = U_WB; end
            U_CLEAR:   begin c.cnt_op = N_ZERO; c.cond = C_ALWAYS; c.target = U_WB; end
            U_APPEND:  begin c.cond = C_FULL; c.target = U_FULL; end
            U_APP_WR:  begin c.mem_wr = 1'b1; c.asel = A_CNTP1; c.wsel = W_NB;
                             c.cnt_op = N_INC; c.cond = C_ALWAYS; c.target = U_WB; end
            U_FULL:    begin c.sset = SS_FULL; c.cond = C_ALWAYS; c.target = U_WB; end
            U_REPL:    begin c.cond = C_POS_BAD; c.target = U_POS_ERR; end
            U_REPL_RD: begin c.mem_rd = 1'b1; c.asel = A_POS; end
            U_REPL_CM: begin c.cond = C_U_LT; c.target = U_LEFT; end
            U_RIGHT:   begin c.k_op = K_POS_M1; end
            U_RLOOP:   begin c.cond = C_K_GT0; c.inv = 1'b1; c.target = U_RPUT; end
            U_RRD:     begin c.mem_rd = 1'b1; c.asel = A_K; end
            U_RCMP:    begin c.cond = C_U_GT; c.inv = 1'b1; c.target = U_RCHK; end
            U_RMOVE:   begin c.mem_wr = 1'b1; c.asel = A_KP1; c.wsel = W_CUR;
                             c.k_op = K_DEC; c.cond = C_ALWAYS; c.target = U_RLOOP; end
            U_RCHK:    begin c.cond = C_U_EQ; c.inv = 1'b1; c.target = U_RPUT; end
            U_RDEL:    begin c.k_op = K_ADD2; c.set_removed = 1'b1; c.cond = C_ALWAYS;
                             c.target = U_DLOOP; end
            U_RPUT:    begin c.mem_wr = 1'b1; c.asel = A_KP1; c.wsel = W_NB;
                             c.cond = C_ALWAYS; c.target = U_WB; end
            U_LEFT:    begin c.k_op = K_POS_P1; end
            U_LLOOP:   begin c.cond = C_K_LE_N; c.inv = 1'b1; c.target = U_LPUT; end
            U_LRD:     begin c.mem_rd = 1'b1; c.asel = A_K; end
            U_LCMP:    begin c.cond = C_U_LT; c.inv = 1'b1; c.target = U_LCHK; end
            U_LMOVE:   begin c.mem_wr = 1'b1; c.asel = A_KM1; c.wsel = W_CUR;
                             c.k_op = K_INC; c.cond = C_ALWAYS; c.target = U_LLOOP; end
            U_LCHK:    begin c.cond = C_U_EQ; c.inv = 1'b1; c.target = U_LPUT; end
            U_LDEL:    begin c.set_removed = 1'b1; c.cond = C_ALWAYS; c.target = U_DMOVE; end
            U_LPUT:    begin c.mem_wr = 1'b1; c.asel = A_KM1; c.wsel = W_NB;
                             c.cond = C_ALWAYS; c.target = U_WB; end
            U_DLOOP:   begin c.cond = C_K_LE_N; c.inv = 1'b1; c.target = U_DEND; end
            U_DRD:     begin c.mem_rd = 1'b1; c.asel = A_K; end
            U_DMOVE:   begin c.mem_wr = 1'b1; c.asel = A_KM1; c.wsel = W_CUR;
                             c.k_op = K_INC; c.cond = C_ALWAYS; c.target = U_DLOOP; end
            U_DEND:    begin c.cnt_op = N_DEC; end
            U_WB:      begin c.cnt_wr = 1'b1; end
            U_DONE:    begin c.done = 1'b1; c.cond = C_ALWAYS; c.target = U_IDLE; end
            default:   begin c.cond = C_ALWAYS; c.target = U_IDLE; end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/snlr_ram.sv =====
`timescale 1ns / 1ps

module snlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/snlr_useq.sv =====
`timescale 1ns / 1ps
`include "sorted_neighbor_list_replace_top_assert.svh"

module snlr_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            hold,
    input  snlr_pkg::flags_t flags,
    output snlr_pkg::ctrl_t  ctrl
);
    import snlr_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    assign ctrl = ucode(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_IN_VALID:   cond_true = req_valid;
            C_CLR_LAST:   cond_true = flags.clr_last;
            C_OP_CLEAR:   cond_true = flags.op_clear;
            C_OP_APPEND:  cond_true = flags.op_append;
            C_OP_REPLACE: cond_true = flags.op_replace;
            C_POS_BAD:    cond_true = flags.pos_bad;
            C_FULL:       cond_true = flags.full;
            C_K_LE_N:     cond_true = flags.k_le_n;
            C_K_GT0:      cond_true = flags.k_gt0;
            C_U_LT:       cond_true = flags.u_lt;
            C_U_GT:       cond_true = flags.u_gt;
            C_U_EQ:       cond_true = flags.u_eq;
            default:      cond_true = 1'b0;
        endcase

        priority if (hold)
        begin
            upc_next = upc_reg;
        end
        else if (cond_true ^ ctrl.inv)
        begin
            upc_next = ctrl.target;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    `SNLR_ASSERT_IMP(a_upc_in_program, 1'b1, upc_reg <= U_DONE,
                     "step counter left the program")
    `SNLR_ASSERT_NXT(a_done_to_idle, ctrl.done && !hold, upc_reg == U_IDLE,
                     "result hand-off did not return to idle")

endmodule

// ===== rtl/snlr_dpath.sv =====
`timescale 1ns / 1ps
`include "sorted_neighbor_list_replace_top_assert.svh"

module snlr_dpath #(
    parameter int VERTICES   = snlr_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = snlr_pkg::MAX_DEGREE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  snlr_pkg::ctrl_t  ctrl,
    input  logic             accept,
    input  snlr_pkg::req_t   req,
    output snlr_pkg::flags_t flags,
    output snlr_pkg::rsp_t   result
);
    import snlr_pkg::*;

    localparam int RW = $clog2(VERTICES);
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int KW = $clog2(MAX_DEGREE + 2);
    localparam int AW = $clog2(VERTICES * MAX_DEGREE);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam logic [RW:0] VLIM = (RW + 1)'(VERTICES);

    logic [1:0]    op_reg, op_next;
    logic [RW-1:0] row_reg, row_next;
    logic [6:0]    pos_reg, pos_next;
    logic [7:0]    nb_reg, nb_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic          removed_reg, removed_next;
    logic [7:0]    rd_reg, rd_next;
    logic [1:0]    status_reg, status_next;
    logic [RW-1:0] clr_idx_reg, clr_idx_next;

    logic [RW-1:0] row_mod;
    logic [KW-1:0] idx;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic [CW-1:0] cnt_rdata;
    logic          cnt_we;
    logic [RW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;

    // row_vertex mod VERTICES, one restoring step per input bit
    always_comb
    begin : row_fold
        logic [RW:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[RW-1:0], req.row_vertex[i]};
            if (r >= VLIM)
            begin
                r = r - VLIM;
            end
        end
        row_mod = r[RW-1:0];
    end

    always_comb
    begin
        unique case (ctrl.asel)
            A_K:     idx = k_reg;
            A_KM1:   idx = k_reg - KW'(1);
            A_KP1:   idx = k_reg + KW'(1);
            A_POS:   idx = KW'(pos_reg);
            A_CNTP1: idx = KW'(cnt_reg) + KW'(1);
            default: idx = k_reg;
        endcase
    end

    assign mem_addr  = row_base_reg + AW'(idx - KW'(1));
    assign mem_wdata = (ctrl.wsel == W_NB) ? nb_reg : mem_rdata;

    snlr_ram #(
        .WIDTH (8),
        .DEPTH (VERTICES * MAX_DEGREE)
    ) u_nbr_ram (
        .clk   (clk),
        .we    (ctrl.mem_wr),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (ctrl.mem_rd),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Count store; the clearing pass after reset zeroes it one row a cycle.
    assign cnt_we    = ctrl.clr_wr | ctrl.cnt_wr;
    assign cnt_waddr = ctrl.clr_wr ? clr_idx_reg : row_reg;
    assign cnt_wdata = ctrl.clr_wr ? '0 : cnt_reg;

    snlr_ram #(
        .WIDTH (CW),
        .DEPTH (VERTICES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (ctrl.cnt_rd),
        .raddr (row_reg),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        op_next       = op_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        nb_next       = nb_reg;
        removed_next  = removed_reg;
        rd_next       = rd_reg;
        status_next   = status_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        clr_idx_next  = clr_idx_reg;
        row_base_next = AW'(row_reg) * AW'(MAX_DEGREE);

        if (accept)
        begin
            op_next      = req.op;
            row_next     = row_mod;
            pos_next     = req.position;
            nb_next      = req.new_neighbor;
            removed_next = 1'b0;
            rd_next      = '0;
            status_next  = ST_OK;
        end

        if (ctrl.cnt_ld)
        begin
            cnt_next = cnt_rdata;
        end
        else
        begin
            unique case (ctrl.cnt_op)
                N_HOLD: cnt_next = cnt_reg;
                N_ZERO: cnt_next = '0;
                N_INC:  cnt_next = cnt_reg + CW'(1);
                N_DEC:  cnt_next = cnt_reg - CW'(1);
            endcase
        end

        unique case (ctrl.k_op)
            K_HOLD:   k_next = k_reg;
            K_POS_P1: k_next = KW'(pos_reg) + KW'(1);
            K_POS_M1: k_next = KW'(pos_reg) - KW'(1);
            K_INC:    k_next = k_reg + KW'(1);
            K_DEC:    k_next = k_reg - KW'(1);
            K_ADD2:   k_next = k_reg + KW'(2);
            default:  k_next = k_reg;
        endcase

        if (ctrl.set_removed)
        begin
            removed_next = 1'b1;
        end
        if (ctrl.rd_ld)
        begin
            rd_next = mem_rdata;
        end

        unique case (ctrl.sset)
            SS_NONE: status_next = status_next;
            SS_POS:  status_next = ST_POS;
            SS_FULL: status_next = ST_FULL;
            default: status_next = status_next;
        endcase

        if (ctrl.clr_wr)
        begin
            clr_idx_next = clr_idx_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        row_reg      <= row_next;
        pos_reg      <= pos_next;
        nb_reg       <= nb_next;
        row_base_reg <= row_base_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        removed_reg  <= removed_next;
        rd_reg       <= rd_next;
        status_reg   <= status_next;
    end

    assign flags.clr_last   = (clr_idx_reg == RW'(VERTICES - 1));
    assign flags.op_clear   = (op_reg == OP_CLEAR);
    assign flags.op_append  = (op_reg == OP_APPEND);
    assign flags.op_replace = (op_reg == OP_REPLACE);
    assign flags.pos_bad    = (pos_reg == 7'd0) || (PW'(pos_reg) > PW'(cnt_reg));
    assign flags.full       = (cnt_reg >= CW'(MAX_DEGREE));
    assign flags.k_le_n     = (k_reg <= KW'(cnt_reg));
    assign flags.k_gt0      = (k_reg != '0);
    assign flags.u_lt       = (nb_reg < mem_rdata);
    assign flags.u_gt       = (nb_reg > mem_rdata);
    assign flags.u_eq       = (nb_reg == mem_rdata);

    assign result.new_count  = 7'(cnt_reg);
    assign result.removed    = removed_reg;
    assign result.read_value = rd_reg;
    assign result.status     = status_reg;

    `SNLR_ASSERT_IMP(a_wr_in_row, ctrl.mem_wr, (idx != '0) && (idx <= KW'(MAX_DEGREE)),
                     "neighbor write outside the row")
    `SNLR_ASSERT_IMP(a_cnt_bound, ctrl.cnt_wr, cnt_reg <= CW'(MAX_DEGREE),
                     "row count written beyond the maximum degree")

endmodule

// ===== rtl/sorted_neighbor_list_replace_top.sv =====
`timescale 1ns / 1ps
`include "sorted_neighbor_list_replace_top_assert.svh"

// Sorted neighbor list store: one list per vertex, kept in descending order,
// with a count per row. Ops: clear row, append (loading), replace at a 1-based
// position (the list is shifted one slot per step so it stays descending; an
// id already present deletes the slot and drops the count), and read entry.
// After reset the block runs a clearing pass over the count store before the
// first transaction is taken. It then works one transaction at a time,
// stepping a small control program. A replace reads and writes each shifted
// entry through the single address port of the neighbor store, which serves
// one read or one write per cycle. The result sits in an output register, so
// the next transaction is taken while a result waits; the final step only
// stalls while an earlier result is still held downstream. row_vertex is
// folded modulo VERTICES; entries past a row's count are never returned.
module sorted_neighbor_list_replace_top #(
    parameter int VERTICES   = snlr_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = snlr_pkg::MAX_DEGREE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  snlr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output snlr_pkg::rsp_t rsp
);
    import snlr_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;
    rsp_t   result;
    logic   accept;
    logic   hold;
    logic   done_fire;

    logic   out_valid_reg, out_valid_next;
    rsp_t   out_data_reg, out_data_next;

    // Request side is open only while the program sits at its idle step.
    assign req_stall = !ctrl.accept;
    assign accept    = ctrl.accept && req_valid;

    // The final step waits while the previous result is still held downstream.
    assign hold      = ctrl.done && out_valid_reg && rsp_stall;
    assign done_fire = ctrl.done && !hold;

    snlr_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .hold      (hold),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    snlr_dpath #(
        .VERTICES   (VERTICES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .accept (accept),
        .req    (req),
        .flags  (flags),
        .result (result)
    );

    // Output register: one result transaction, held until taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        priority if (done_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    `SNLR_ASSERT_IMP(a_rsp_from_done, $rose(out_valid_reg), $past(ctrl.done),
                     "result appeared without the final program step")

endmodule

// ===== tb/sv/sorted_neighbor_list_replace_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted neighbor list store.
// Requests go in through one send task, which also runs the list predictor
// at the moment a transaction is taken, so any stimulus that looks at the
// predicted lists sees the state after every earlier request. A free-running
// checker pops one expected response per response transaction.
module sorted_neighbor_list_replace_top_tb;

    import snlr_pkg::*;

    localparam int VERTICES   = VERTICES_DEF;
    localparam int MAX_DEGREE = MAX_DEGREE_DEF;

    // The package has no name for the read code; it is what is left over.
    localparam logic [1:0] OP_READ = 2'd3;

    // Drain with margin beyond the longest replace.
    localparam int DRAIN_CYCLES = 16 * MAX_DEGREE + 64;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Predicted contents: entries are 1-based to match list positions.
    logic [7:0] list_mem [VERTICES][1:MAX_DEGREE];
    int         list_len [VERTICES];

    rsp_t expected_rsp_q [$];
    int   err_count      = 0;
    int   sent_count     = 0;

    // Idle and stall rates, in percent, set per phase.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    sorted_neighbor_list_replace_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Receiver side: stall at the phase's rate.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Apply one request to the predicted lists and return the response.
    // Replace walks the list like the hardware: shift smaller entries right
    // or larger entries left, and drop the slot if an equal id turns up.
    function automatic rsp_t apply_req(req_t r);
        rsp_t       res;
        int         row;
        int         pos;
        int         n;
        int         k;
        logic [7:0] u;
        row = r.row_vertex % VERTICES;
        pos = r.position;
        u   = r.new_neighbor;
        n   = list_len[row];
        res = '0;
        res.status = ST_OK;
        case (r.op)
            OP_CLEAR:
            begin
                n = 0;
            end
            OP_APPEND:
            begin
                if (n >= MAX_DEGREE)
                    res.status = ST_FULL;
                else
                begin
                    n++;
                    list_mem[row][n] = u;
                end
            end
            OP_REPLACE:
            begin
                if (pos < 1 || pos > n)
                    res.status = ST_POS;
                else if (u < list_mem[row][pos])
                begin
                    // new id is smaller: walk toward the tail
                    k = pos + 1;
                    while (k <= n && u < list_mem[row][k])
                    begin
                        list_mem[row][k-1] = list_mem[row][k];
                        k++;
                    end
                    if (k <= n && u == list_mem[row][k])
                    begin
                        while (k <= n)
                        begin
                            list_mem[row][k-1] = list_mem[row][k];
                            k++;
                        end
                        n--;
                        res.removed = 1'b1;
                    end
                    else
                        list_mem[row][k-1] = u;
                end
                else
                begin
                    // new id is larger or equal: walk toward the head
                    k = pos - 1;
                    while (k > 0 && u > list_mem[row][k])
                    begin
                        list_mem[row][k+1] = list_mem[row][k];
                        k--;
                    end
                    if (k > 0 && u == list_mem[row][k])
                    begin
                        k += 2;
                        while (k <= n)
                        begin
                            list_mem[row][k-1] = list_mem[row][k];
                            k++;
                        end
                        n--;
                        res.removed = 1'b1;
                    end
                    else
                        list_mem[row][k+1] = u;
                end
            end
            default:
            begin
                if (pos < 1 || pos > n)
                    res.status = ST_POS;
                else
                    res.read_value = list_mem[row][pos];
            end
        endcase
        list_len[row] = n;
        res.new_count = n[6:0];
        return res;
    endfunction

    function automatic req_t mk_req(logic [1:0] op, int row, int pos, int nb);
        req_t r;
        r.op           = op;
        r.row_vertex   = row[7:0];
        r.position     = pos[6:0];
        r.new_neighbor = nb[7:0];
        return r;
    endfunction

    // Drive one request transaction and predict its response once taken.
    // Valid stays up across back-to-back transactions when no gap is drawn.
    task automatic send_req(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp_q.insert(expected_rsp_q.size(), apply_req(item));
        sent_count++;
    endtask

    // Response checker: every response transaction against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("response with no request outstanding");
                err_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.new_count !== want.new_count)
                begin
                    $error("new_count: expected %0d, actual %0d", want.new_count, rsp.new_count);
                    err_count++;
                end
                if (rsp.removed !== want.removed)
                begin
                    $error("removed: expected %0d, actual %0d", want.removed, rsp.removed);
                    err_count++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, actual %0d",
                           want.read_value, rsp.read_value);
                    err_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    err_count++;
                end
            end
        end
    end

    // Hand-picked cases: empty rows, bad positions (zero, one past the end,
    // the largest code), extreme ids and rows, replace with the same id,
    // shifts in both directions, duplicates found either way, and a replace
    // on an unsorted row.
    task automatic test_directed();
        send_req(mk_req(OP_READ,    0,   1,   0));
        send_req(mk_req(OP_REPLACE, 0,   0,   5));
        send_req(mk_req(OP_CLEAR,   255, 0,   0));
        send_req(mk_req(OP_APPEND,  255, 0,   255));
        send_req(mk_req(OP_APPEND,  255, 0,   200));
        send_req(mk_req(OP_APPEND,  255, 0,   100));
        send_req(mk_req(OP_APPEND,  255, 0,   0));
        send_req(mk_req(OP_READ,    255, 1,   0));
        send_req(mk_req(OP_READ,    255, 4,   0));
        send_req(mk_req(OP_READ,    255, 5,   0));
        send_req(mk_req(OP_READ,    255, 0,   0));
        send_req(mk_req(OP_READ,    255, 127, 0));
        send_req(mk_req(OP_REPLACE, 255, 2,   200));
        send_req(mk_req(OP_REPLACE, 255, 4,   150));
        send_req(mk_req(OP_REPLACE, 255, 1,   50));
        send_req(mk_req(OP_REPLACE, 255, 1,   150));
        send_req(mk_req(OP_REPLACE, 255, 3,   150));
        send_req(mk_req(OP_REPLACE, 255, 2,   255));
        send_req(mk_req(OP_REPLACE, 255, 127, 255));
        send_req(mk_req(OP_APPEND,  0,   0,   7));
        send_req(mk_req(OP_APPEND,  0,   0,   30));
        send_req(mk_req(OP_REPLACE, 0,   1,   20));
        send_req(mk_req(OP_READ,    0,   2,   0));
        send_req(mk_req(OP_CLEAR,   255, 0,   0));
        send_req(mk_req(OP_READ,    255, 1,   0));
        send_req(mk_req(OP_CLEAR,   0,   0,   0));
    endtask

    // Fill one row to capacity, push past it, then run the two longest
    // replaces: a walk from the tail to a duplicate at the head, and a walk
    // from the head to the tail.
    task automatic test_row_full();
        int i;
        send_req(mk_req(OP_CLEAR, 7, 0, 0));
        for (i = 0; i < MAX_DEGREE; i++)
            send_req(mk_req(OP_APPEND, 7, $urandom_range(127), 255 - 4 * i));
        send_req(mk_req(OP_APPEND,  7, 0, 1));
        send_req(mk_req(OP_APPEND,  7, 127, 254));
        send_req(mk_req(OP_READ,    7, MAX_DEGREE, 0));
        send_req(mk_req(OP_REPLACE, 7, MAX_DEGREE, 255));
        send_req(mk_req(OP_APPEND,  7, 0, 2));
        send_req(mk_req(OP_REPLACE, 7, 1, 0));
        send_req(mk_req(OP_READ,    7, MAX_DEGREE, 0));
    endtask

    // Well-formed traffic: clear a row, load a strictly descending list with
    // random content, then work on it with replaces (fresh ids and ids already
    // present), reads, and a little noise (bad positions, stray appends).
    task automatic test_sorted_lists(input int n_items);
        bit [255:0] used;
        int         stop_at;
        int         row;
        int         len;
        int         picked;
        int         v;
        int         m;
        int         n;
        int         sel;
        int         pos;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at)
        begin
            // mostly a few hot rows, so state carries over between sequences
            row = ($urandom_range(3) == 0) ? $urandom_range(255) : 85 * $urandom_range(3);
            len = ($urandom_range(9) == 0) ? $urandom_range(MAX_DEGREE) : $urandom_range(1, 10);
            send_req(mk_req(OP_CLEAR, row, $urandom_range(127), $urandom_range(255)));
            used   = '0;
            picked = 0;
            while (picked < len)
            begin
                v = $urandom_range(255);
                if (!used[v])
                begin
                    used[v] = 1'b1;
                    picked++;
                end
            end
            for (v = 255; v >= 0; v--)
                if (used[v])
                    send_req(mk_req(OP_APPEND, row, $urandom_range(127), v));
            for (m = $urandom_range(3, 12); m > 0; m--)
            begin
                n   = list_len[row];
                sel = $urandom_range(99);
                pos = (n > 0) ? $urandom_range(1, n) : 0;
                if (sel < 55 && n > 0)
                begin
                    // about a third of replaces reuse an id already listed
                    v = ($urandom_range(2) == 0) ? list_mem[row][$urandom_range(1, n)]
                                                 : $urandom_range(255);
                    send_req(mk_req(OP_REPLACE, row, pos, v));
                end
                else if (sel < 75 && n > 0)
                    send_req(mk_req(OP_READ, row, pos, $urandom_range(255)));
                else if (sel < 90)
                begin
                    pos = ($urandom_range(1) == 0) ? 0 : $urandom_range(n + 1, 127);
                    send_req(mk_req($urandom_range(1) ? OP_READ : OP_REPLACE, row, pos,
                                    $urandom_range(255)));
                end
                else
                    send_req(mk_req(OP_APPEND, row, $urandom_range(127), $urandom_range(255)));
            end
        end
    endtask

    // Unshaped traffic: every field drawn over its whole encoding.
    task automatic test_random_noise(input int n_items);
        int i;
        for (i = 0; i < n_items; i++)
            send_req(mk_req(2'($urandom_range(3)), $urandom_range(255), $urandom_range(127),
                            $urandom_range(255)));
    endtask

    initial
    begin
        // Reset once; the block then clears its counts before taking work,
        // which the request handshake absorbs.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_row_full();

        // Idling phases over the shaped traffic.
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_sorted_lists(200);
        send_idle_pct = 47; recv_stall_pct = 0;
        test_sorted_lists(200);
        send_idle_pct = 0;  recv_stall_pct = 47;
        test_sorted_lists(200);
        send_idle_pct = 6;  recv_stall_pct = 6;
        test_sorted_lists(200);
        test_random_noise(200);

        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        // Catch any stray response after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond a run where every request is a longest replace.
    initial
    begin
        #(50_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
